// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// implication in the next cycle
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/mi4_pkg.sv =====
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants, command and status types for the 4x4 matrix inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ENTRIES    = 16;
   localparam int IDX_W      = 4;
   localparam int DET_W      = 64;
   localparam int CHUNKS     = 4;
   localparam int MAG_W      = CHUNKS * DATA_WIDTH;
   localparam int ACC_W      = 4 * DATA_WIDTH + 8;
   localparam int DIV_W      = 4 * DATA_WIDTH + 2 * FRAC_BITS + 8;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
   localparam int MAC_LAST   = CHUNKS + 3;
   localparam int MAC_CNT_W  = $clog2(MAC_LAST + 1);
   localparam int STEP_W     = 4;

   localparam logic [ACC_W-1:0] DET_HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);
   localparam logic [ACC_W-1:0] DET_LIM  = ACC_W'(1) << (DET_W - 1);
   localparam logic [DIV_W-1:0] VAL_LIM  = DIV_W'(1) << (DATA_WIDTH - 1);

   // operand source of a multiply-accumulate
   localparam logic [1:0] SRC_ENTRY = 2'd0;
   localparam logic [1:0] SRC_TERM  = 2'd1;
   localparam logic [1:0] SRC_COF   = 2'd2;

   // destination of a multiply-accumulate
   localparam logic [1:0] DST_ACC_SET = 2'd0;
   localparam logic [1:0] DST_ACC_ADD = 2'd1;
   localparam logic [1:0] DST_DET_ADD = 2'd2;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic             mac_go;
      logic [1:0]       a_src;
      logic [IDX_W-1:0] a_idx;
      logic [IDX_W-1:0] b_idx;
      logic             neg;
      logic [1:0]       dest;
      logic [1:0]       t_sel;
      logic             t_store;
      logic             cof_store;
      logic             det_clr;
      logic             det_fin;
      logic             div_go;
      logic             emit;
      logic [1:0]       row;
      logic [1:0]       col;
      logic             last;
      logic             det_only;
   } cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic div_busy;
      logic singular;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic       a_term;
      logic [1:0] ar;
      logic [1:0] ac;
      logic [1:0] br;
      logic [1:0] bc;
      logic       sub;
   } step_type;

   // nine multiply-accumulate steps of one 3x3 cofactor
   function automatic step_type step_info(input logic [STEP_W-1:0] s);
      step_type st;
      st = '0;
      case (s)
         4'd0: st = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd2, 1'b0};
         4'd1: st = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd1, 1'b1};
         4'd2: st = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd2, 1'b0};
         4'd3: st = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd0, 1'b1};
         4'd4: st = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd1, 1'b0};
         4'd5: st = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd0, 1'b1};
         4'd6: st = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0};
         4'd7: st = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd1, 1'b1};
         4'd8: st = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd2, 1'b0};
         default: st = '0;
      endcase
      return st;
   endfunction

   // m-th index of 0..3 with x left out
   function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] m);
      return (m < x) ? m : m + 2'd1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mi4_ctrl.sv =====
// ----------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: loads entries, walks the cofactor steps, determinant, divides
// and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_ctrl import mi4_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire logic     req_mode,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MAC    = 4'd1;
   localparam logic [3:0] S_MWAIT  = 4'd2;
   localparam logic [3:0] S_TSTORE = 4'd3;
   localparam logic [3:0] S_COF    = 4'd4;
   localparam logic [3:0] S_DMAC   = 4'd5;
   localparam logic [3:0] S_DWAIT  = 4'd6;
   localparam logic [3:0] S_DFIN   = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_DIVW   = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  load_cnt_ff, load_cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        col_cnt_ff, col_cnt_in;
   logic [IDX_W-1:0]  item_ff, item_in;
   logic              det_phase_ff, det_phase_in;
   logic              mode_ff, mode_in;

   logic       accept;
   logic [1:0] i_sel, j_sel;
   step_type   st;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign i_sel     = det_phase_ff ? 2'd0 : item_ff[1:0];
   assign j_sel     = det_phase_ff ? col_cnt_ff : item_ff[3:2];
   assign st        = step_info(step_ff);

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      step_in      = step_ff;
      col_cnt_in   = col_cnt_ff;
      item_in      = item_ff;
      det_phase_in = det_phase_ff;
      mode_in      = mode_ff;

      cmd          = '0;
      cmd.wr_en    = accept;
      cmd.wr_idx   = load_cnt_ff;
      cmd.a_idx    = {skip_idx(i_sel, st.ar), skip_idx(j_sel, st.ac)};
      cmd.b_idx    = {skip_idx(i_sel, st.br), skip_idx(j_sel, st.bc)};
      cmd.a_src    = st.a_term ? SRC_TERM : SRC_ENTRY;
      cmd.neg      = st.sub ^ (st.a_term & (i_sel[0] ^ j_sel[0]));
      cmd.dest     = (step_ff inside {4'd0, 4'd2, 4'd4, 4'd6}) ? DST_ACC_SET : DST_ACC_ADD;
      cmd.t_sel    = st.a_term ? st.bc : step_ff[2:1];
      cmd.row      = mode_ff ? 2'd0 : item_ff[3:2];
      cmd.col      = mode_ff ? 2'd0 : item_ff[1:0];
      cmd.last     = mode_ff || (item_ff == IDX_W'(ENTRIES - 1));
      cmd.det_only = mode_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (load_cnt_ff == IDX_W'(ENTRIES - 1)) begin
                  load_cnt_in  = '0;
                  mode_in      = req_mode;
                  det_phase_in = 1'b1;
                  col_cnt_in   = '0;
                  step_in      = '0;
                  cmd.det_clr  = 1'b1;
                  state_in     = S_MAC;
               end else begin
                  load_cnt_in = load_cnt_ff + IDX_W'(1);
               end
            end
         end
         S_MAC: begin
            cmd.mac_go = 1'b1;
            state_in   = S_MWAIT;
         end
         S_MWAIT: begin
            if (!stat.mac_busy) begin
               if (step_ff inside {4'd1, 4'd3, 4'd5}) begin
                  state_in = S_TSTORE;
               end else if (step_ff == 4'd8) begin
                  state_in = S_COF;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = S_MAC;
               end
            end
         end
         S_TSTORE: begin
            cmd.t_store = 1'b1;
            step_in     = step_ff + STEP_W'(1);
            state_in    = S_MAC;
         end
         S_COF: begin
            cmd.cof_store = 1'b1;
            if (det_phase_ff) begin
               state_in = S_DMAC;
            end else if (stat.singular) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DMAC: begin
            cmd.mac_go = 1'b1;
            cmd.a_src  = SRC_COF;
            cmd.b_idx  = {2'd0, col_cnt_ff};
            cmd.neg    = 1'b0;
            cmd.dest   = DST_DET_ADD;
            state_in   = S_DWAIT;
         end
         S_DWAIT: begin
            if (!stat.mac_busy) begin
               if (col_cnt_ff == 2'd3) begin
                  state_in = S_DFIN;
               end else begin
                  col_cnt_in = col_cnt_ff + 2'd1;
                  step_in    = '0;
                  state_in   = S_MAC;
               end
            end
         end
         S_DFIN: begin
            cmd.det_fin  = 1'b1;
            det_phase_in = 1'b0;
            item_in      = '0;
            step_in      = '0;
            state_in     = mode_ff ? S_EMIT : S_MAC;
         end
         S_DIV: begin
            cmd.div_go = 1'b1;
            state_in   = S_DIVW;
         end
         S_DIVW: begin
            if (!stat.div_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (mode_ff || (item_ff == IDX_W'(ENTRIES - 1))) begin
                  state_in = S_IDLE;
               end else begin
                  item_in  = item_ff + IDX_W'(1);
                  step_in  = '0;
                  state_in = S_MAC;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         load_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      col_cnt_ff   <= col_cnt_in;
      item_ff      <= item_in;
      det_phase_ff <= det_phase_in;
      mode_ff      <= mode_in;
   end

endmodule

`default_nettype wire

// ===== rtl/mi4_dp.sv =====
// ----------------------------------------------------------------------------
// mi4_dp
// Datapath: entry store, chunked multiply-accumulate, determinant rounding,
// restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_dp import mi4_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [DATA_WIDTH-1:0]  req_element_value,
   input  wire cmd_type                       cmd,
   output stat_type                           stat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]       rsp_entry_value,
   output logic [1:0]                         rsp_entry_row,
   output logic [1:0]                         rsp_entry_col,
   output logic signed [DET_W-1:0]            rsp_determinant,
   output logic                               rsp_singular,
   output logic                               rsp_overflow,
   output logic                               rsp_last_of_run
);

   localparam int DW = DATA_WIDTH;

   // entry store
   logic [DW-1:0]    mat_ff [ENTRIES];
   logic [DW-1:0]    rd_q_ff;
   logic [IDX_W-1:0] rd_addr;

   // multiply-accumulate
   logic                 mac_busy_ff;
   logic [MAC_CNT_W-1:0] mac_cnt_ff;
   logic [IDX_W-1:0]     b_idx_ff;
   logic                 neg_ff;
   logic [1:0]           dest_ff;
   logic [1:0]           src_ff;
   logic [1:0]           tsel_ff;
   logic [MAG_W-1:0]     amag_ff;
   logic                 asgn_ff;
   logic [DW-1:0]        bmag_ff;
   logic                 psgn_ff;
   logic [2*DW-1:0]      prod_ff;
   logic [ACC_W-1:0]     sum_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_W-1:0]     det_ff;
   logic [ACC_W-1:0]     term_ff [3];
   logic [ACC_W-1:0]     cof_ff;

   logic [ACC_W-1:0] a_val, a_abs, prod_signed;
   logic [DW-1:0]    b_abs;
   logic [2*DW-1:0]  prod_in;

   // determinant result
   logic [DET_W-1:0] det_bits_ff;
   logic             det_ovf_ff;
   logic             sing_ff;
   logic [ACC_W-1:0] det_abs, det_rnd, cof_abs;
   logic [DET_W-1:0] det_bits_in;
   logic             det_ovf_in;

   // divider
   logic                 div_busy_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DIV_W:0]       rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     div_d_ff;
   logic                 qneg_ff;
   logic [DW-1:0]        val_ff;
   logic                 vovf_ff;
   logic [DIV_W:0]       shifted, diff;
   logic [DIV_W-1:0]     div_n;
   logic [DW-1:0]        val_in;
   logic                 vovf_in;

   // output register
   logic             rsp_valid_ff;
   logic [DW-1:0]    value_ff;
   logic [1:0]       row_ff, col_ff;
   logic [DET_W-1:0] det_out_ff;
   logic             sing_out_ff, ovf_out_ff, last_ff;

   assign rd_addr = cmd.mac_go ? cmd.a_idx : b_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mat_ff[cmd.wr_idx] <= req_element_value;
      end
      rd_q_ff <= mat_ff[rd_addr];
   end

   always_comb begin
      case (src_ff)
         SRC_ENTRY: a_val = {{(ACC_W-DW){rd_q_ff[DW-1]}}, rd_q_ff};
         SRC_TERM:  a_val = term_ff[tsel_ff];
         SRC_COF:   a_val = cof_ff;
         default:   a_val = '0;
      endcase
   end

   assign a_abs       = a_val[ACC_W-1] ? -a_val : a_val;
   assign b_abs       = rd_q_ff[DW-1] ? -rd_q_ff : rd_q_ff;
   assign prod_in     = amag_ff[MAG_W-1 -: DW] * bmag_ff;
   assign prod_signed = psgn_ff ? -sum_ff : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_busy_ff <= 1'b0;
      end else if (cmd.mac_go) begin
         mac_busy_ff <= 1'b1;
      end else if (mac_busy_ff && (mac_cnt_ff == MAC_CNT_W'(MAC_LAST))) begin
         mac_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_go) begin
         mac_cnt_ff <= '0;
         b_idx_ff   <= cmd.b_idx;
         neg_ff     <= cmd.neg;
         dest_ff    <= cmd.dest;
         src_ff     <= cmd.a_src;
         tsel_ff    <= cmd.t_sel;
      end else if (mac_busy_ff) begin
         mac_cnt_ff <= mac_cnt_ff + MAC_CNT_W'(1);
         if (mac_cnt_ff == MAC_CNT_W'(0)) begin
            amag_ff <= a_abs[MAG_W-1:0];
            asgn_ff <= a_val[ACC_W-1];
            sum_ff  <= '0;
         end
         if (mac_cnt_ff == MAC_CNT_W'(1)) begin
            bmag_ff <= b_abs;
            psgn_ff <= asgn_ff ^ rd_q_ff[DW-1] ^ neg_ff;
         end
         if ((mac_cnt_ff >= MAC_CNT_W'(2)) && (mac_cnt_ff < MAC_CNT_W'(CHUNKS + 2))) begin
            prod_ff <= prod_in;
            amag_ff <= amag_ff << DW;
         end
         if ((mac_cnt_ff >= MAC_CNT_W'(3)) && (mac_cnt_ff < MAC_CNT_W'(CHUNKS + 3))) begin
            sum_ff <= (sum_ff << DW) + ACC_W'(prod_ff);
         end
         if (mac_cnt_ff == MAC_CNT_W'(MAC_LAST)) begin
            case (dest_ff)
               DST_ACC_SET: acc_ff <= prod_signed;
               DST_ACC_ADD: acc_ff <= acc_ff + prod_signed;
               DST_DET_ADD: det_ff <= det_ff + prod_signed;
               default:     acc_ff <= acc_ff;
            endcase
         end
      end
      if (cmd.det_clr) begin
         det_ff <= '0;
      end
      if (cmd.t_store) begin
         term_ff[cmd.t_sel] <= acc_ff;
      end
      if (cmd.cof_store) begin
         cof_ff <= acc_ff;
      end
   end

   // determinant rounding and saturation
   assign det_abs = det_ff[ACC_W-1] ? -det_ff : det_ff;
   assign det_rnd = (det_abs + DET_HALF) >> (2 * FRAC_BITS);

   always_comb begin
      if (det_ff[ACC_W-1]) begin
         det_ovf_in  = det_rnd > DET_LIM;
         det_bits_in = det_ovf_in ? {1'b1, {(DET_W-1){1'b0}}} : -det_rnd[DET_W-1:0];
      end else begin
         det_ovf_in  = det_rnd > (DET_LIM - ACC_W'(1));
         det_bits_in = det_ovf_in ? {1'b0, {(DET_W-1){1'b1}}} : det_rnd[DET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.det_fin) begin
         det_bits_ff <= det_bits_in;
         det_ovf_ff  <= det_ovf_in;
         sing_ff     <= (det_ff == '0);
      end
   end

   // restoring divider, one quotient bit per cycle
   assign cof_abs = cof_ff[ACC_W-1] ? -cof_ff : cof_ff;
   assign div_n   = (DIV_W'(cof_abs) << (2 * FRAC_BITS + 1)) + DIV_W'(det_abs);
   assign shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, div_d_ff};

   always_comb begin
      if (qneg_ff) begin
         vovf_in = quo_ff > VAL_LIM;
         val_in  = vovf_in ? {1'b1, {(DW-1){1'b0}}} : -quo_ff[DW-1:0];
      end else begin
         vovf_in = quo_ff > (VAL_LIM - DIV_W'(1));
         val_in  = vovf_in ? {1'b0, {(DW-1){1'b1}}} : quo_ff[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_go) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && (div_cnt_ff == DIV_CNT_W'(DIV_W))) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_go) begin
         rem_ff     <= '0;
         quo_ff     <= div_n;
         div_d_ff   <= DIV_W'(det_abs) << 1;
         qneg_ff    <= cof_ff[ACC_W-1] ^ det_ff[ACC_W-1];
         div_cnt_ff <= '0;
      end else if (div_busy_ff) begin
         if (div_cnt_ff == DIV_CNT_W'(DIV_W)) begin
            val_ff  <= val_in;
            vovf_ff <= vovf_in;
         end else begin
            rem_ff     <= diff[DIV_W] ? shifted : diff;
            quo_ff     <= {quo_ff[DIV_W-2:0], ~diff[DIV_W]};
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         value_ff    <= (cmd.det_only || sing_ff) ? '0 : val_ff;
         row_ff      <= cmd.row;
         col_ff      <= cmd.col;
         det_out_ff  <= det_bits_ff;
         sing_out_ff <= sing_ff;
         ovf_out_ff  <= det_ovf_ff || (!cmd.det_only && !sing_ff && vovf_ff);
         last_ff     <= cmd.last;
      end
   end

   assign stat.mac_busy = mac_busy_ff;
   assign stat.div_busy = div_busy_ff;
   assign stat.singular = sing_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = value_ff;
   assign rsp_entry_row   = row_ff;
   assign rsp_entry_col   = col_ff;
   assign rsp_determinant = det_out_ff;
   assign rsp_singular    = sing_out_ff;
   assign rsp_overflow    = ovf_out_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

// ===== rtl/matrix_inverse_4x4_core.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_core
// 4x4 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// Entries stream in row-major, one per cycle while req_stall is low. The
// sixteenth entry starts the solve and holds req_stall high until the run is
// out. Every product goes through one shared 32x32 multiplier, a chunk at a
// time; the determinant takes four cofactors plus their products. Each
// inverse entry then needs its cofactor plus a restoring divide that yields
// one quotient bit per cycle. A singular matrix skips the divides. Results
// sit in an output register, so loading of the next matrix overlaps the last
// result waiting.
`default_nettype none

module matrix_inverse_4x4_core import mi4_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_element_value,
   input  wire logic                         req_mode,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_entry_value,
   output logic [1:0]                        rsp_entry_row,
   output logic [1:0]                        rsp_entry_col,
   output logic signed [DET_W-1:0]           rsp_determinant,
   output logic                              rsp_singular,
   output logic                              rsp_overflow,
   output logic                              rsp_last_of_run
);

   cmd_type  cmd;
   stat_type stat;

   mi4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   mi4_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_element_value (req_element_value),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_entry_row     (rsp_entry_row),
      .rsp_entry_col     (rsp_entry_col),
      .rsp_determinant   (rsp_determinant),
      .rsp_singular      (rsp_singular),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== rtl/mi4_checker.sv =====
// ----------------------------------------------------------------------------
// mi4_checker
// Port-level checks for the 4x4 matrix inverse core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mi4_checker import mi4_pkg::*; (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic signed [DATA_WIDTH-1:0] rsp_entry_value,
   input wire logic [1:0]                   rsp_entry_row,
   input wire logic [1:0]                   rsp_entry_col,
   input wire logic signed [DET_W-1:0]      rsp_determinant,
   input wire logic                         rsp_singular,
   input wire logic                         rsp_last_of_run
);

   // a stalled item holds
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_entry_value) && $stable(rsp_determinant) && $stable(rsp_last_of_run))

   // singular gives zero entries and zero determinant
   `ASSERT_IMP(a_sing_zero, clock, reset, rsp_valid && rsp_singular, (rsp_entry_value == '0) && (rsp_determinant == '0))

   // a run ending anywhere but row 3 col 3 is determinant only, with zero entry
   `ASSERT_IMP(a_det_only, clock, reset, rsp_valid && rsp_last_of_run && (rsp_entry_row != 2'd3 || rsp_entry_col != 2'd3), (rsp_entry_value == '0) && (rsp_entry_row == 2'd0) && (rsp_entry_col == 2'd0))

   // input is held off while a run is still being emitted
   `ASSERT_IMP(a_busy_stall, clock, reset, rsp_valid && !rsp_last_of_run, req_stall)

endmodule

bind matrix_inverse_4x4_core mi4_checker u_mi4_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4x4 fixed-point matrix inverse core. Matrices
// are streamed in one entry per item. A wide-integer adjugate/determinant
// predictor queues the results expected for each matrix, and every result
// item is compared field by field as it leaves the core. Both handshakes are
// throttled at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import mi4_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic [1:0]                   row;
      logic [1:0]                   col;
      logic signed [DET_W-1:0]      det;
      logic                         sing;
      logic                         ovf;
      logic                         last;
   } inv_item_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         mode;
      logic                         typed;
      logic signed [DET_W-1:0]      det;
      logic                         sing;
   } stim_row_type;

   localparam int WATCHDOG = 20000;
   localparam int RAND_ITEMS = 384;
   localparam logic signed [DATA_WIDTH-1:0] ONE = 1 <<< FRAC_BITS;
   localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [DATA_WIDTH-1:0] req_element_value = '0;
   logic                         req_mode = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [DATA_WIDTH-1:0] rsp_entry_value;
   logic [1:0]                   rsp_entry_row;
   logic [1:0]                   rsp_entry_col;
   logic signed [DET_W-1:0]      rsp_determinant;
   logic                         rsp_singular;
   logic                         rsp_overflow;
   logic                         rsp_last_of_run;

   inv_item_type                 inverse_q[$];
   logic signed [DATA_WIDTH-1:0] entry_store[16];
   int                           entries_loaded = 0;
   int                           errors = 0;
   int                           idle_cycles = 0;
   int                           n_full = 0, n_det = 0, n_sing = 0, n_sat = 0;
   bit                           no_idle = 1'b0;
   stim_row_type                 directed[$];

   matrix_inverse_4x4_core i_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic wide_type minor3(input wide_type m[16], input int i, input int j);
      int       rr[3], cc[3];
      int       n, k;
      wide_type t0, t1, t2;
      n = 0;
      for (k = 0; k < 4; k++) if (k != i) begin rr[n] = k; n++; end
      n = 0;
      for (k = 0; k < 4; k++) if (k != j) begin cc[n] = k; n++; end
      t0 = m[rr[1]*4+cc[1]] * m[rr[2]*4+cc[2]] - m[rr[1]*4+cc[2]] * m[rr[2]*4+cc[1]];
      t1 = m[rr[1]*4+cc[0]] * m[rr[2]*4+cc[2]] - m[rr[1]*4+cc[2]] * m[rr[2]*4+cc[0]];
      t2 = m[rr[1]*4+cc[0]] * m[rr[2]*4+cc[1]] - m[rr[1]*4+cc[1]] * m[rr[2]*4+cc[0]];
      return m[rr[0]*4+cc[0]] * t0 - m[rr[0]*4+cc[1]] * t1 + m[rr[0]*4+cc[2]] * t2;
   endfunction

   function automatic logic [63:0] saturate(input wide_type v, input int bits, inout logic ovf);
      wide_type lim;
      lim = wide_type'(1) <<< (bits - 1);
      if (v > lim - 1) begin ovf = 1'b1; return 64'(lim - 1); end
      if (v < -lim) begin ovf = 1'b1; return 64'(-lim); end
      return 64'(v);
   endfunction

   // computes the whole run of results for the stored matrix
   task automatic predict_inverse(input logic det_only);
      wide_type     m[16], cof[16];
      wide_type     det, mag, num, q, adet;
      logic         sing, dovf, ovf;
      logic [63:0]  dbits;
      inv_item_type it;
      int           k;
      for (k = 0; k < 16; k++) m[k] = wide_type'(entry_store[k]);
      for (k = 0; k < 16; k++)
         cof[k] = ((k / 4 + k % 4) % 2) ? -minor3(m, k / 4, k % 4) : minor3(m, k / 4, k % 4);
      det = 0;
      for (k = 0; k < 4; k++) det += m[k] * cof[k];
      sing = (det == 0);
      adet = (det < 0) ? -det : det;
      mag = (adet + (wide_type'(1) <<< (2*FRAC_BITS - 1))) >>> (2*FRAC_BITS);
      dovf = 1'b0;
      dbits = saturate((det < 0) ? -mag : mag, DET_W, dovf);
      if (sing) n_sing++;
      if (dovf) n_sat++;
      if (det_only) begin
         n_det++;
         it = '{'0, 2'd0, 2'd0, dbits, sing, dovf, 1'b1};
         inverse_q.push_back(it);
         return;
      end
      n_full++;
      for (k = 0; k < 16; k++) begin
         ovf = dovf;
         it.value = '0;
         if (!sing) begin
            num = cof[(k % 4)*4 + k / 4] <<< (2*FRAC_BITS);
            q = (((num < 0) ? -num : num) * 2 + adet) / (adet * 2);
            if ((num < 0) != (det < 0)) q = -q;
            it.value = DATA_WIDTH'(saturate(q, DATA_WIDTH, ovf));
         end
         it.row = 2'(k / 4);
         it.col = 2'(k % 4);
         it.det = dbits;
         it.sing = sing;
         it.ovf = ovf;
         it.last = (k == 15);
         inverse_q.push_back(it);
      end
   endtask

   task automatic send_entry(input logic signed [DATA_WIDTH-1:0] v, input logic mode);
      while (!no_idle && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= v;
      req_mode <= mode;
      do @(posedge clock); while (req_stall);
      entry_store[entries_loaded] = v;
      if (entries_loaded == 15) begin
         entries_loaded = 0;
         predict_inverse(mode);
      end else begin
         entries_loaded++;
      end
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_entry(input int kind, input int k);
      case (kind)
         0: return $signed($urandom_range(0, 8*ONE)) - 4*ONE;
         1: return $urandom;
         2: case ($urandom_range(3))
               0: return MAXV;
               1: return MINV;
               2: return '0;
               default: return $urandom;
            endcase
         3: return (k / 4 == 3) ? entry_store[k - 4]
                                : $signed($urandom_range(0, 4*ONE)) - 2*ONE;
         default: return (k % 5 == 0) ? $signed($urandom_range(1, 6)) : '0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (no_idle) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      inv_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverse_q.size() == 0) begin
            $display("%0t: unexpected result item value %h", $time, rsp_entry_value);
            errors++;
         end else begin
            e = inverse_q.pop_front();
            if (rsp_entry_value !== e.value || rsp_entry_row !== e.row ||
                rsp_entry_col !== e.col || rsp_determinant !== e.det ||
                rsp_singular !== e.sing || rsp_overflow !== e.ovf ||
                rsp_last_of_run !== e.last) begin
               $display("%0t: mismatch exp val=%h r=%0d c=%0d det=%h s=%b o=%b l=%b",
                        $time, e.value, e.row, e.col, e.det, e.sing, e.ovf, e.last);
               $display("%0t:          act val=%h r=%0d c=%0d det=%h s=%b o=%b l=%b",
                        $time, rsp_entry_value, rsp_entry_row, rsp_entry_col,
                        rsp_determinant, rsp_singular, rsp_overflow, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, inverse_q.size());
         $display("** matrix_inverse_4x4_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stim_row_type r;
      inv_item_type it;
      int           k, kind, sent;
      // identity in determinant mode, then the zero matrix as a full inverse
      for (k = 0; k < 16; k++) begin
         r = '{(k % 5 == 0) ? ONE : '0, 1'b1, k == 15, 64'sd1 <<< 32, 1'b0};
         directed.push_back(r);
      end
      for (k = 0; k < 16; k++) begin
         r = '{'0, 1'b0, k == 15, '0, 1'b1};
         directed.push_back(r);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_entry(directed[i].value, directed[i].mode);
         if (directed[i].typed) begin
            repeat (directed[i].mode ? 1 : 16) void'(inverse_q.pop_back());
            for (k = 0; k < (directed[i].mode ? 1 : 16); k++) begin
               it = '{'0, directed[i].mode ? 2'd0 : 2'(k / 4),
                      directed[i].mode ? 2'd0 : 2'(k % 4),
                      directed[i].det, directed[i].sing, 1'b0,
                      directed[i].mode || k == 15};
               inverse_q.push_back(it);
            end
         end
      end
      // hold the sender off until the core has drained
      req_valid <= 1'b0;
      wait (inverse_q.size() == 0);
      @(posedge clock);
      sent = 0;
      while (sent < RAND_ITEMS) begin
         no_idle = (sent >= 128 && sent < 224);
         kind = $urandom_range(4);
         for (k = 0; k < 16; k++) begin
            send_entry(pick_entry(kind, k), $urandom_range(3) == 0);
            sent++;
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;
      wait (inverse_q.size() == 0);
      repeat (50) @(posedge clock);
      $display("run: %0d full inverses, %0d determinant-only, %0d singular,",
               n_full, n_det, n_sing);
      $display("     %0d with saturated determinant", n_sat);
      if (errors == 0)
         $display("** matrix_inverse_4x4_core: PASSED **");
      else
         $display("** matrix_inverse_4x4_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/mi4_pkg.sv
rtl/mi4_ctrl.sv
rtl/mi4_dp.sv
rtl/matrix_inverse_4x4_core.sv
rtl/mi4_checker.sv
verif/tb.sv
